// File: rtl/bpt_pkg.sv
package bpt_pkg;

   // default build parameters
   localparam int unsigned FRAC_BITS_DEF     = 16;
   localparam int unsigned CORDIC_STAGES_DEF = 24;

   // register map, indexed by paddr[2]
   localparam logic [0:0] REG_AMOUNT = 1'b0;
   localparam logic signed [31:0] AMOUNT_RESET = 32'sd65536;

   // angle constants in q2.30
   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   // 2*pi with 61 fraction bits
   localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C235;

   // largest term magnitude kept before the final add
   localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;

   // arctangent of 2^-k in q2.30, truncated
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   // point data that rides along the pipeline
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        rnd;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
   } side_type;

   // 2*pi with 2*frac fraction bits, rounded
   function automatic logic [63:0] two_pi_fix(input int unsigned frac);
      int unsigned csh;
      csh = 61 - 2 * frac;
      return (TWO_PI_Q61 >> csh) + ((TWO_PI_Q61 >> (csh - 1)) & 64'd1);
   endfunction

endpackage

// File: rtl/bpt_sqrt_cell.sv
module bpt_sqrt_cell import bpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] in_rad,
   input  logic [35:0] in_rem,
   input  logic [31:0] in_root,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [63:0] out_rad,
   output logic [35:0] out_rem,
   output logic [31:0] out_root,
   output side_type    out_side
);

   logic        valid_ff;
   logic [63:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   side_type    side_ff;
   logic [35:0] rem_sh, trial;
   logic        ge;

   // one root bit per cell from the top two radicand bits
   always_comb begin
      rem_sh  = {in_rem[33:0], in_rad[63:62]};
      trial   = {2'b00, in_root, 2'b01};
      ge      = rem_sh >= trial;
      rem_in  = ge ? rem_sh - trial : rem_sh;
      root_in = {in_root[30:0], ge};
      rad_in  = {in_rad[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

`ifndef SYNTH
   // partial remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> rem_ff <= {3'b000, root_ff, 1'b0})
      else $error("sqrt remainder out of bound");
`endif

endmodule

// File: rtl/bpt_mod_cell.sv
module bpt_mod_cell import bpt_pkg::*; #(
   parameter logic [63:0] DIVISOR = 64'd1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] in_rem,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [63:0] out_rem,
   output side_type    out_side
);

   logic        valid_ff;
   logic [63:0] rem_ff, rem_in;
   side_type    side_ff;

   // conditional subtract of one shifted copy of 2*pi
   always_comb begin
      rem_in = (in_rem >= DIVISOR) ? in_rem - DIVISOR : in_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_side  = side_ff;

`ifndef SYNTH
   // each cell leaves less than its own divisor
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> rem_ff < DIVISOR)
      else $error("modulo cell left an unreduced remainder");
`endif

endmodule

// File: rtl/bpt_cordic_cell.sv
module bpt_cordic_cell import bpt_pkg::*; #(
   parameter int unsigned STAGE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [33:0] in_cx,
   input  logic signed [33:0] in_cy,
   input  logic signed [33:0] in_z,
   input  logic               in_flip,
   input  side_type           in_side,
   output logic               out_valid,
   output logic signed [33:0] out_cx,
   output logic signed [33:0] out_cy,
   output logic signed [33:0] out_z,
   output logic               out_flip,
   output side_type           out_side
);

   localparam int unsigned K = STAGE % 32;
   localparam logic signed [33:0] ATAN_K = {2'b00, ATAN_Q30[K]};

   logic               valid_ff;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, z_ff, z_in;
   logic               flip_ff;
   side_type           side_ff;
   logic signed [33:0] dx, dy;

   // one micro-rotation, direction from the sign of the residual angle
   always_comb begin
      dx = in_cy >>> K;
      dy = in_cx >>> K;
      if (!in_z[33]) begin
         cx_in = in_cx - dx;
         cy_in = in_cy + dy;
         z_in  = in_z - ATAN_K;
      end else begin
         cx_in = in_cx + dx;
         cy_in = in_cy - dy;
         z_in  = in_z + ATAN_K;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         z_ff    <= z_in;
         flip_ff <= in_flip;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;
   assign out_z     = z_ff;
   assign out_flip  = flip_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/blade_point_transform_3d.sv
// channel  | direction | beat carries
// req      | in        | aff_x, aff_y, rand_frac, acc_x, acc_y, acc_z
// rsp      | out       | new_x, new_y, new_z
// csr      | in/out    | apb register access, amount at offset 0
//
// one beat accepted per cycle while req_stall is low, fully pipelined through three cell chains
// each beat passes the 32 square root cells, the modulo 2*pi cells and the cordic cells
// synchronous reset clears valid bits and sets amount to 1.0
// while a result beat is stalled the whole pipeline holds and req_stall is high
module blade_point_transform_3d import bpt_pkg::*; #(
   parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF,
   parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_aff_x,
   input  logic signed [31:0] req_aff_y,
   input  logic [15:0]        req_rand_frac,
   input  logic signed [31:0] req_acc_x,
   input  logic signed [31:0] req_acc_y,
   input  logic signed [31:0] req_acc_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y,
   output logic signed [31:0] rsp_new_z,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int unsigned RED_STAGES = 62 - 2 * FRAC_BITS;
   localparam logic [63:0] TWO_PI_FIX = two_pi_fix(FRAC_BITS);
   localparam int          ANG_SH     = 2 * FRAC_BITS - 30;
   localparam int unsigned SHR        = (ANG_SH >= 0) ? ANG_SH : 0;
   localparam int unsigned SHL        = (ANG_SH < 0) ? -ANG_SH : 0;
   localparam int unsigned TERM_SH    = FRAC_BITS + 30;

   logic               en;
   logic signed [31:0] amount_ff;

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff <= AMOUNT_RESET;
      end else if (psel && penable && pwrite && pready && (paddr[2:2] == REG_AMOUNT)) begin
         amount_ff <= pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2:2] == REG_AMOUNT) ? amount_ff : 32'd0;

   // pipeline advances unless a result beat is held
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // squares of the point coordinates
   logic [31:0] xabs, yabs;
   logic        v1_ff;
   logic [63:0] xsq_ff, ysq_ff;
   side_type    side1_ff, side_req;

   always_comb begin
      xabs = req_aff_x[31] ? 32'(-req_aff_x) : req_aff_x;
      yabs = req_aff_y[31] ? 32'(-req_aff_y) : req_aff_y;
      side_req = '{x: req_aff_x, y: req_aff_y, rnd: req_rand_frac,
                   acc_x: req_acc_x, acc_y: req_acc_y, acc_z: req_acc_z};
   end

   // sum of squares
   logic        v2_ff;
   logic [63:0] ssq_ff;
   side_type    side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xsq_ff   <= xabs * xabs;
         ysq_ff   <= yabs * yabs;
         side1_ff <= side_req;
         ssq_ff   <= xsq_ff + ysq_ff;
         side2_ff <= side1_ff;
      end
   end

   // square root chain, one result bit per cell
   logic        sq_v    [33];
   logic [63:0] sq_rad  [33];
   logic [35:0] sq_rem  [33];
   logic [31:0] sq_root [33];
   side_type    sq_side [33];

   assign sq_v[0]    = v2_ff;
   assign sq_rad[0]  = ssq_ff;
   assign sq_rem[0]  = 36'd0;
   assign sq_root[0] = 32'd0;
   assign sq_side[0] = side2_ff;

   for (genvar g = 0; g < 32; g++) begin : g_sqrt
      bpt_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[g]),
         .in_rad    (sq_rad[g]),
         .in_rem    (sq_rem[g]),
         .in_root   (sq_root[g]),
         .in_side   (sq_side[g]),
         .out_valid (sq_v[g+1]),
         .out_rad   (sq_rad[g+1]),
         .out_rem   (sq_rem[g+1]),
         .out_root  (sq_root[g+1]),
         .out_side  (sq_side[g+1])
      );
   end

   // radius times random fraction, then times |amount|
   logic [47:0] tprod;
   logic [31:0] amt_abs;
   logic        v3_ff, v4_ff;
   logic [31:0] t_ff;
   logic [63:0] rmag_ff;
   side_type    side3_ff, side4_ff;

   always_comb begin
      tprod   = sq_root[32] * sq_side[32].rnd;
      amt_abs = amount_ff[31] ? 32'(-amount_ff) : amount_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= sq_v[32];
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= tprod[47:16];
         side3_ff <= sq_side[32];
         rmag_ff  <= t_ff * amt_abs;
         side4_ff <= side3_ff;
      end
   end

   // modulo 2*pi chain, restoring subtract per cell
   logic        md_v    [RED_STAGES+1];
   logic [63:0] md_rem  [RED_STAGES+1];
   side_type    md_side [RED_STAGES+1];

   assign md_v[0]    = v4_ff;
   assign md_rem[0]  = rmag_ff;
   assign md_side[0] = side4_ff;

   for (genvar g = 0; g < RED_STAGES; g++) begin : g_mod
      bpt_mod_cell #(
         .DIVISOR (TWO_PI_FIX << (RED_STAGES - 1 - g))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (md_v[g]),
         .in_rem    (md_rem[g]),
         .in_side   (md_side[g]),
         .out_valid (md_v[g+1]),
         .out_rem   (md_rem[g+1]),
         .out_side  (md_side[g+1])
      );
   end

   // sign of amount, conversion to q2.30 and fold into +-pi/2
   logic [63:0]        rem_adj, a_raw;
   logic signed [34:0] a0, a1, a2;
   logic               fold;
   logic               ang_v_ff;
   logic signed [33:0] ang_ff;
   logic               flip_ff;
   side_type           side5_ff;

   always_comb begin
      rem_adj = md_rem[RED_STAGES];
      if (amount_ff[31] && (rem_adj != 64'd0)) begin
         rem_adj = TWO_PI_FIX - rem_adj;
      end
      a_raw = (rem_adj >> SHR) << SHL;
      a0    = {1'b0, a_raw[33:0]};
      a1    = (a0 > PI_Q30) ? a0 - TWO_PI_Q30 : a0;
      fold  = 1'b0;
      a2    = a1;
      if (a1 > HALF_PI_Q30) begin
         a2   = a1 - PI_Q30;
         fold = 1'b1;
      end else if (a1 < -HALF_PI_Q30) begin
         a2   = a1 + PI_Q30;
         fold = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_v_ff <= 1'b0;
      end else if (en) begin
         ang_v_ff <= md_v[RED_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff   <= a2[33:0];
         flip_ff  <= fold;
         side5_ff <= md_side[RED_STAGES];
      end
   end

   // cordic chain for sine and cosine
   logic               cr_v    [CORDIC_STAGES+1];
   logic signed [33:0] cr_cx   [CORDIC_STAGES+1];
   logic signed [33:0] cr_cy   [CORDIC_STAGES+1];
   logic signed [33:0] cr_z    [CORDIC_STAGES+1];
   logic               cr_flip [CORDIC_STAGES+1];
   side_type           cr_side [CORDIC_STAGES+1];

   assign cr_v[0]    = ang_v_ff;
   assign cr_cx[0]   = GAIN_Q30;
   assign cr_cy[0]   = 34'sd0;
   assign cr_z[0]    = ang_ff;
   assign cr_flip[0] = flip_ff;
   assign cr_side[0] = side5_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      bpt_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cr_v[g]),
         .in_cx     (cr_cx[g]),
         .in_cy     (cr_cy[g]),
         .in_z      (cr_z[g]),
         .in_flip   (cr_flip[g]),
         .in_side   (cr_side[g]),
         .out_valid (cr_v[g+1]),
         .out_cx    (cr_cx[g+1]),
         .out_cy    (cr_cy[g+1]),
         .out_z     (cr_z[g+1]),
         .out_flip  (cr_flip[g+1]),
         .out_side  (cr_side[g+1])
      );
   end

   // trig combinations and weighted coordinates
   logic signed [33:0] cosv, sinv;
   logic signed [63:0] px, py;
   logic               ve0_ff, ve1_ff, ve2_ff, ve3_ff;
   logic signed [34:0] trig_ff [3];
   logic signed [63:0] p_ff    [3];
   side_type           side_e0_ff, side_e1_ff, side_e2_ff, side_e3_ff;

   always_comb begin
      cosv = cr_flip[CORDIC_STAGES] ? -cr_cx[CORDIC_STAGES] : cr_cx[CORDIC_STAGES];
      sinv = cr_flip[CORDIC_STAGES] ? -cr_cy[CORDIC_STAGES] : cr_cy[CORDIC_STAGES];
      px   = amount_ff * cr_side[CORDIC_STAGES].x;
      py   = amount_ff * cr_side[CORDIC_STAGES].y;
   end

   // magnitudes and signs of the term operands
   logic [62:0] pmag_ff [3];
   logic [33:0] tmag_ff [3];
   logic        neg_ff  [3];
   logic [62:0] pmag    [3];
   logic [33:0] tmag    [3];
   logic signed [63:0] pneg [3];
   logic signed [34:0] tneg [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pneg[j] = -p_ff[j];
         tneg[j] = -trig_ff[j];
         pmag[j] = p_ff[j][63] ? pneg[j][62:0] : p_ff[j][62:0];
         tmag[j] = trig_ff[j][34] ? tneg[j][33:0] : trig_ff[j][33:0];
      end
   end

   // split products, then recombine, scale and cap
   logic [65:0] lo_ff   [3];
   logic [64:0] hi_ff   [3];
   logic        neg2_ff [3];
   logic [96:0] prod    [3];
   logic [96:0] quot    [3];
   logic [40:0] mcap    [3];
   logic [40:0] m_ff    [3];
   logic        neg3_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod[j] = {hi_ff[j], 32'd0} + 97'(lo_ff[j]);
         quot[j] = prod[j] >> TERM_SH;
         mcap[j] = (quot[j] > 97'(TERM_CAP)) ? TERM_CAP : quot[j][40:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve0_ff <= 1'b0;
         ve1_ff <= 1'b0;
         ve2_ff <= 1'b0;
         ve3_ff <= 1'b0;
      end else if (en) begin
         ve0_ff <= cr_v[CORDIC_STAGES];
         ve1_ff <= ve0_ff;
         ve2_ff <= ve1_ff;
         ve3_ff <= ve2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff[0] <= 35'(cosv) + 35'(sinv);
         trig_ff[1] <= 35'(cosv) - 35'(sinv);
         trig_ff[2] <= 35'(sinv) - 35'(cosv);
         p_ff[0]    <= px;
         p_ff[1]    <= px;
         p_ff[2]    <= py;
         side_e0_ff <= cr_side[CORDIC_STAGES];
         for (int j = 0; j < 3; j++) begin
            pmag_ff[j] <= pmag[j];
            tmag_ff[j] <= tmag[j];
            neg_ff[j]  <= p_ff[j][63] ^ trig_ff[j][34];
            lo_ff[j]   <= pmag_ff[j][31:0] * tmag_ff[j];
            hi_ff[j]   <= pmag_ff[j][62:32] * tmag_ff[j];
            neg2_ff[j] <= neg_ff[j];
            m_ff[j]    <= mcap[j];
            neg3_ff[j] <= neg2_ff[j];
         end
         side_e1_ff <= side_e0_ff;
         side_e2_ff <= side_e1_ff;
         side_e3_ff <= side_e2_ff;
      end
   end

   // add to the running point and saturate
   logic signed [42:0] acc  [3];
   logic signed [42:0] sum  [3];
   logic signed [31:0] sat  [3];

   always_comb begin
      acc[0] = 43'(side_e3_ff.acc_x);
      acc[1] = 43'(side_e3_ff.acc_y);
      acc[2] = 43'(side_e3_ff.acc_z);
      for (int j = 0; j < 3; j++) begin
         sum[j] = neg3_ff[j] ? acc[j] - signed'({2'b00, m_ff[j]})
                             : acc[j] + signed'({2'b00, m_ff[j]});
         if (sum[j] > 43'sd2147483647) begin
            sat[j] = 32'sh7FFFFFFF;
         end else if (sum[j] < -43'sd2147483648) begin
            sat[j] = 32'sh80000000;
         end else begin
            sat[j] = sum[j][31:0];
         end
      end
   end

   // result register
   logic signed [31:0] new_x_ff, new_y_ff, new_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ve3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         new_x_ff <= sat[0];
         new_y_ff <= sat[1];
         new_z_ff <= sat[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_x = new_x_ff;
   assign rsp_new_y = new_y_ff;
   assign rsp_new_z = new_z_ff;

`ifndef SYNTH
   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   // folded angle stays within +-pi/2
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      ang_v_ff |-> (35'(ang_ff) <= HALF_PI_Q30) && (35'(ang_ff) >= -HALF_PI_Q30))
      else $error("folded angle out of range");

   // zero weight gives zero terms
   a_zero_weight: assert property (@(posedge clock) disable iff (reset)
      ve3_ff && (amount_ff == 32'sd0) |->
         (m_ff[0] == 41'd0) && (m_ff[1] == 41'd0) && (m_ff[2] == 41'd0))
      else $error("nonzero term with zero weight");

   // input is held back only while a result beat waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");
`endif

endmodule
